>>> hw/rtl/frc_pkg.sv
// fault record codec package: item types, status codes, record constants
// and the CRC-32 column tables worked out at elaboration
// no dependencies
package frc_pkg;

  // record layout constants
  localparam logic [31:0] REC_MAGIC    = 32'h5452_4448;
  localparam logic [15:0] REC_SIZE     = 16'd20;
  localparam logic [15:0] REC_FLAG_TS  = 16'h0001;
  localparam logic [15:0] REC_VER_RST  = 16'h0001;
  localparam int          REC_CRC_BYTES = 16;
  localparam int          CRC_MSG_BITS  = REC_CRC_BYTES * 8;

  // reflected crc-32 constants
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // operation kinds
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_INVALID_STATE = 2'd1;
  localparam logic [1:0] ST_CORRUPTED     = 2'd2;
  localparam logic [1:0] ST_UNSUPPORTED   = 2'd3;

  typedef struct packed {
    logic        kind;
    logic        fault_present;
    logic        ts_available;
    logic [15:0] code;
    logic [31:0] timestamp;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] length;
    logic [15:0] flags;
    logic [31:0] rec_crc;
  } frc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        present;
    logic        ts_valid;
    logic [15:0] code_out;
    logic [15:0] flags_out;
    logic [31:0] timestamp_out;
    logic [31:0] crc_out;
  } frc_out_t;

  // one crc step per bit, lsb first
  function automatic logic [31:0] crc_shift8(input logic [31:0] c_in);
    logic [31:0] c;
    c = c_in;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // linear part: crc contribution of each message bit (bit 8*byte + bit-in-byte)
  function automatic logic [CRC_MSG_BITS-1:0][31:0] crc_cols_f();
    logic [CRC_MSG_BITS-1:0][31:0] cols;
    logic [31:0] c;
    logic [7:0]  b;
    for (int j = 0; j < CRC_MSG_BITS; j++) begin
      c = 32'd0;
      for (int i = 0; i < REC_CRC_BYTES; i++) begin
        b = ((j >> 3) == i) ? (8'd1 << (j & 7)) : 8'd0;
        c = crc_shift8(c ^ {24'd0, b});
      end
      cols[j] = c;
    end
    return cols;
  endfunction

  // affine part: crc of an all-zero message including init and final xor
  function automatic logic [31:0] crc_offset_f();
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 0; i < REC_CRC_BYTES; i++) begin
      c = crc_shift8(c);
    end
    return c ^ CRC_INIT;
  endfunction

  localparam logic [CRC_MSG_BITS-1:0][31:0] CRC_COLS   = crc_cols_f();
  localparam logic [31:0]                   CRC_OFFSET = crc_offset_f();

endpackage

>>> hw/rtl/fault_record_codec_crc32.sv
// fault record codec top level: input register, crc xor tree and checks,
// result register; depends on frc_pkg
//
// Encodes a fault into, or checks, a 20-byte fault history record guarded by
// a reflected CRC-32 over its first 16 bytes. One item is accepted per clock
// cycle while in_ready is high. The item is held in the input register, then
// its result moves to the result register and is held there until out_ready.
// The CRC is a flat XOR tree of constant columns over the 128 record bits, so
// the path between the two registers is that tree plus the field compares.
// in_ready stays high while the input register is empty or will move on, so
// while a finished result waits for out_ready a new item is taken only into
// an empty input register. format_version resets to 1; the user must write it
// via cfg_we/cfg_wdata only while the block is idle, which the block does not enforce.
module fault_record_codec_crc32
  import frc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  frc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output frc_out_t    out_data
);

  logic [15:0] fmt_ver_r;
  logic        s1_valid_r;
  frc_in_t     s1_data_r;
  logic        out_valid_r;
  frc_out_t    out_data_r;
  logic        out_adv;
  logic        s1_adv;
  logic [127:0] rec_w;
  logic [CRC_MSG_BITS-1:0] msg_w;
  logic [31:0] crc_w;
  logic [15:0] enc_flags;
  logic [31:0] enc_ts;
  frc_out_t    res_nxt;

  // format version register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_ver_r <= REC_VER_RST;
    end else if (cfg_we) begin
      fmt_ver_r <= cfg_wdata;
    end
  end

  // handshake: result stage moves when empty or taken, input stage follows
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ready = s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // encode fields
  assign enc_flags = s1_data_r.ts_available ? REC_FLAG_TS : 16'd0;
  assign enc_ts    = s1_data_r.ts_available ? s1_data_r.timestamp : 32'd0;

  // first 16 record bytes, big-endian
  always_comb begin
    if (s1_data_r.kind == KIND_ENCODE) begin
      rec_w = {REC_MAGIC, fmt_ver_r, REC_SIZE, s1_data_r.code, enc_flags, enc_ts};
    end else begin
      rec_w = {s1_data_r.magic, s1_data_r.version, s1_data_r.length,
               s1_data_r.code, s1_data_r.flags, s1_data_r.timestamp};
    end
  end

  // byte 0 goes first, each byte lsb first
  always_comb begin
    for (int i = 0; i < REC_CRC_BYTES; i++) begin
      for (int k = 0; k < 8; k++) begin
        msg_w[8*i + k] = rec_w[120 - 8*i + k];
      end
    end
  end

  // crc as xor of constant columns
  always_comb begin
    crc_w = CRC_OFFSET;
    for (int j = 0; j < CRC_MSG_BITS; j++) begin
      if (msg_w[j]) begin
        crc_w = crc_w ^ CRC_COLS[j];
      end
    end
  end

  // result selection
  always_comb begin
    res_nxt = '0;
    if (s1_data_r.kind == KIND_ENCODE) begin
      if (!s1_data_r.fault_present) begin
        res_nxt.status = ST_INVALID_STATE;
      end else begin
        res_nxt.status        = ST_OK;
        res_nxt.code_out      = s1_data_r.code;
        res_nxt.flags_out     = enc_flags;
        res_nxt.timestamp_out = enc_ts;
        res_nxt.crc_out       = crc_w;
      end
    end else begin
      res_nxt.crc_out = crc_w;
      priority if (s1_data_r.magic != REC_MAGIC || s1_data_r.length != REC_SIZE ||
                   s1_data_r.rec_crc != crc_w) begin
        res_nxt.status = ST_CORRUPTED;
      end else if (s1_data_r.version != fmt_ver_r) begin
        res_nxt.status = ST_UNSUPPORTED;
      end else if ((s1_data_r.flags & ~REC_FLAG_TS) != 16'd0) begin
        res_nxt.status = ST_CORRUPTED;
      end else begin
        res_nxt.status        = ST_OK;
        res_nxt.present       = 1'b1;
        res_nxt.ts_valid      = s1_data_r.flags[0];
        res_nxt.code_out      = s1_data_r.code;
        res_nxt.timestamp_out = s1_data_r.flags[0] ? s1_data_r.timestamp : 32'd0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/frc_checker.sv
// port-level checks for the fault record codec, bound to the top level
// depends on frc_pkg
module frc_checker
  import frc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input frc_out_t out_data
);

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an absent fault carries nothing but its status
  a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_INVALID_STATE |->
      !out_data.present && out_data.code_out == 16'd0 &&
      out_data.flags_out == 16'd0 && out_data.timestamp_out == 32'd0 &&
      out_data.crc_out == 32'd0)
    else $error("invalid state result not cleared");

  // any failure reports no fault
  a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      !out_data.present && !out_data.ts_valid && out_data.timestamp_out == 32'd0)
    else $error("failed item reports fault data");

  // a decoded fault is ok, has no flag word, and a timestamp only when flagged
  a_decode_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.present |->
      out_data.status == ST_OK && out_data.flags_out == 16'd0 &&
      (out_data.ts_valid || out_data.timestamp_out == 32'd0))
    else $error("decoded fault result inconsistent");

endmodule

bind fault_record_codec_crc32 frc_checker u_frc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
